/* hdl/inverse_log_power_series_eval_unit_macros.svh */
// assertion macros used by the checker
`ifndef INVERSE_LOG_POWER_SERIES_EVAL_UNIT_MACROS_SVH
`define INVERSE_LOG_POWER_SERIES_EVAL_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ILPS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ILPS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ilps_pkg.sv */
package ilps_pkg;

	typedef enum logic [1:0] {
		SH_0,
		SH_32,
		SH_33,
		SH_64
	} mac_sh_t;

	typedef struct packed {
		logic        issue;
		logic        first;
		mac_sh_t     sh;
		logic [31:0] a;
		logic [31:0] b;
	} mac_cmd_t;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_SAT     = 2'd2;

	localparam logic [2:0] REG_TERM_COUNT = 3'd6;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam int LOG_FRAC_BITS = 48;
	localparam int DIV_BITS = 82;
	// log2(e) as Q2.62, pre-shifted for 19 extra quotient bits
	localparam logic [81:0] DIV_NUM = 82'h5C55_1D94_AE0B_F85E << 19;
	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

endpackage

/* hdl/ilps_mac.sv */
module ilps_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  ilps_pkg::mac_cmd_t cmd,
	output logic [127:0]       acc
);
	import ilps_pkg::*;

	logic          issue_s1;
	logic          first_s1;
	mac_sh_t       sh_s1;
	logic [63:0]   prod_s1;
	logic [127:0]  acc_q;
	logic [127:0]  addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		sh_s1    <= cmd.sh;
		prod_s1  <= cmd.a * cmd.b;
		if (issue_s1) begin
			acc_q <= (first_s1 ? 128'd0 : acc_q) + addend;
		end
	end

	always_comb begin
		unique case (sh_s1)
			SH_0:    addend = {64'd0, prod_s1};
			SH_32:   addend = {32'd0, prod_s1, 32'd0};
			SH_33:   addend = {31'd0, prod_s1, 33'd0};
			SH_64:   addend = {prod_s1, 64'd0};
			default: addend = {64'd0, prod_s1};
		endcase
	end

	assign acc = acc_q;

endmodule

/* hdl/inverse_log_power_series_eval_unit.sv */
// channel   | valid         | stall         | payload
// ----------+---------------+---------------+-----------------------------
// sample    | sample_valid  | sample_stall  | sample_x
// result    | result_valid  | result_stall  | series_value, status
// apb       | psel/penable  | pready (=1)   | paddr, pwdata, prdata
//
// one transaction at a time: sample_stall is high from acceptance until the result leaves
// steps: normalize, log2 by squaring (48 fraction bits on the shared 32x32 mac),
//   divide (82 quotient bits), then a multiply and an add per term
// x of zero or one: result valid in the cycle after acceptance, with status invalid
// reset clears control and the configuration registers, no clearing pass
// a stalled result holds in its output register until taken
module inverse_log_power_series_eval_unit #(
	parameter int MAX_TERMS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [31:0] sample_x,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [63:0] series_value,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ilps_pkg::*;

	localparam int CW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM,
		S_SQ,
		S_DMAG,
		S_DIV,
		S_TMAG,
		S_HPREP,
		S_HMUL,
		S_HADD,
		S_DONE
	} state_t;

	// configuration registers
	logic [31:0] coef_q [MAX_TERMS];
	logic [2:0]  term_count_q;

	// sequencer and datapath registers
	state_t       state_q;
	logic [2:0]   ph_q;
	logic [6:0]   cnt_q;
	logic [63:0]  m_q;
	logic [4:0]   p_q;
	logic [47:0]  frac_q;
	logic [52:0]  dmag_q;
	logic [52:0]  rem_q;
	logic [63:0]  quo_q;
	logic [63:0]  tmag_q;
	logic         tneg_q;
	logic [63:0]  acc_q;
	logic [63:0]  amag_q;
	logic         neg_q;
	logic [63:0]  mres_q;
	logic         sat_q;
	logic [2:0]   term_q;
	logic         res_valid_q;
	logic [63:0]  res_q;
	logic [1:0]   status_q;

	mac_cmd_t     cmd;
	logic [127:0] mac_acc;

	logic [2:0]   cfg_idx;
	logic [31:0]  coef_rd;
	logic         cfg_wr;

	logic [52:0]  dmag_c;
	logic [53:0]  rem_c;
	logic         div_ge;
	logic [6:0]   div_idx;
	logic [63:0]  q_inc;
	logic [2:0]   n_terms;

	logic [63:0]  mr_r;
	logic [63:0]  mr_r2;
	logic         mr_big;
	logic [63:0]  mul_res;
	logic         mul_sat;
	logic [63:0]  cext;
	logic [63:0]  sum_raw;
	logic [63:0]  add_res;
	logic         add_sat;

	ilps_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.acc    (mac_acc)
	);

	// apb side, a write lands whenever addressed; software keeps them to idle periods, the block does not enforce it
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;
	// horner coefficient for the current term
	assign coef_rd = coef_q[term_q[CW-1:0]];

	always_comb begin
		if (cfg_idx < 3'(MAX_TERMS)) begin
			prdata = coef_q[cfg_idx[CW-1:0]];
		end else if (cfg_idx == REG_TERM_COUNT) begin
			prdata = {29'd0, term_count_q};
		end else begin
			prdata = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TERMS; i++) begin
				coef_q[i] <= 32'd0;
			end
			term_count_q <= 3'd0;
		end else if (cfg_wr) begin
			if (cfg_idx < 3'(MAX_TERMS)) begin
				coef_q[cfg_idx[CW-1:0]] <= pwdata;
			end else if (cfg_idx == REG_TERM_COUNT) begin
				term_count_q <= pwdata[2:0];
			end
		end
	end

	// shared multiplier schedule: squaring for log2, 64x64 for horner
	always_comb begin
		cmd       = '0;
		cmd.first = (ph_q == 3'd0);
		unique case (state_q)
			S_SQ: begin
				cmd.issue = (ph_q <= 3'd2);
				priority case (ph_q)
					3'd0: begin
						cmd.a = m_q[31:0];  cmd.b = m_q[31:0];  cmd.sh = SH_0;
					end
					3'd1: begin
						cmd.a = m_q[31:0];  cmd.b = m_q[63:32]; cmd.sh = SH_33;
					end
					default: begin
						cmd.a = m_q[63:32]; cmd.b = m_q[63:32]; cmd.sh = SH_64;
					end
				endcase
			end
			S_HMUL: begin
				cmd.issue = (ph_q <= 3'd3);
				priority case (ph_q)
					3'd0: begin
						cmd.a = amag_q[31:0];  cmd.b = tmag_q[31:0];  cmd.sh = SH_0;
					end
					3'd1: begin
						cmd.a = amag_q[31:0];  cmd.b = tmag_q[63:32]; cmd.sh = SH_32;
					end
					3'd2: begin
						cmd.a = amag_q[63:32]; cmd.b = tmag_q[31:0];  cmd.sh = SH_32;
					end
					default: begin
						cmd.a = amag_q[63:32]; cmd.b = tmag_q[63:32]; cmd.sh = SH_64;
					end
				endcase
			end
			default: cmd.issue = 1'b0;
		endcase
	end

	// log magnitude with 48 fraction bits
	always_comb begin
		if (p_q[4]) begin
			dmag_c = (53'(p_q[3:0]) << LOG_FRAC_BITS) + 53'(frac_q);
		end else begin
			dmag_c = (53'(5'd16 - p_q) << LOG_FRAC_BITS) - 53'(frac_q);
		end
	end

	// restoring divide, one quotient bit per cycle
	assign div_idx = 7'(DIV_BITS - 1) - cnt_q;
	assign rem_c   = {rem_q, DIV_NUM[div_idx]};
	assign div_ge  = rem_c >= {1'b0, dmag_q};
	assign q_inc   = quo_q + 64'd1;
	assign n_terms = (term_count_q > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : term_count_q;

	// product to q32.32, round half away from zero, clamp
	always_comb begin
		mr_r    = mac_acc[95:32];
		mr_big  = (mac_acc[127:96] != 32'd0) || (mr_r > NEG_LIMIT);
		mr_r2   = mr_r + {63'd0, mac_acc[31]};
		mul_sat = 1'b0;
		if (mr_big) begin
			mul_sat = 1'b1;
			mul_res = neg_q ? NEG_LIMIT : POS_LIMIT;
		end else if (!neg_q && mr_r2[63]) begin
			mul_sat = 1'b1;
			mul_res = POS_LIMIT;
		end else if (neg_q && (mr_r2 > NEG_LIMIT)) begin
			mul_sat = 1'b1;
			mul_res = NEG_LIMIT;
		end else begin
			mul_res = neg_q ? (64'd0 - mr_r2) : mr_r2;
		end
	end

	// add of the coefficient, saturating
	always_comb begin
		cext    = {{16{coef_rd[31]}}, coef_rd, 16'd0};
		sum_raw = mres_q + cext;
		add_sat = (mres_q[63] == cext[63]) && (sum_raw[63] != mres_q[63]);
		if (add_sat) begin
			add_res = mres_q[63] ? NEG_LIMIT : POS_LIMIT;
		end else begin
			add_res = sum_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 3'd0;
			cnt_q       <= 7'd0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						if ((sample_x == 32'd0) || (sample_x == ONE_Q16)) begin
							res_q       <= 64'd0;
							status_q    <= STATUS_INVALID;
							res_valid_q <= 1'b1;
							state_q     <= S_DONE;
						end else begin
							m_q     <= {sample_x, 32'd0};
							p_q     <= 5'd31;
							state_q <= S_NORM;
						end
					end
				end
				// leading one search, one bit per cycle
				S_NORM: begin
					if (m_q[63]) begin
						ph_q    <= 3'd0;
						cnt_q   <= 7'd0;
						frac_q  <= 48'd0;
						state_q <= S_SQ;
					end else begin
						m_q <= {m_q[62:0], 1'b0};
						p_q <= p_q - 5'd1;
					end
				end
				// one fraction bit of log2 per squaring
				S_SQ: begin
					if (ph_q == 3'd4) begin
						ph_q <= 3'd0;
						if (mac_acc[127]) begin
							m_q    <= mac_acc[127:64];
							frac_q <= {frac_q[46:0], 1'b1};
						end else begin
							m_q    <= mac_acc[126:63];
							frac_q <= {frac_q[46:0], 1'b0};
						end
						if (cnt_q == 7'(LOG_FRAC_BITS - 1)) begin
							state_q <= S_DMAG;
						end else begin
							cnt_q <= cnt_q + 7'd1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_DMAG: begin
					if (dmag_c == 53'd0) begin
						res_q       <= 64'd0;
						status_q    <= STATUS_INVALID;
						res_valid_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						dmag_q  <= dmag_c;
						tneg_q  <= !p_q[4];
						rem_q   <= 53'd0;
						quo_q   <= 64'd0;
						cnt_q   <= 7'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= div_ge ? 53'(rem_c - {1'b0, dmag_q}) : rem_c[52:0];
					quo_q <= {quo_q[62:0], div_ge};
					if (cnt_q == 7'(DIV_BITS - 1)) begin
						state_q <= S_TMAG;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_TMAG: begin
					tmag_q <= {1'b0, q_inc[63:1]};
					acc_q  <= 64'd0;
					sat_q  <= 1'b0;
					if (n_terms == 3'd0) begin
						res_q       <= 64'd0;
						status_q    <= STATUS_OK;
						res_valid_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						term_q  <= n_terms - 3'd1;
						state_q <= S_HPREP;
					end
				end
				S_HPREP: begin
					amag_q  <= acc_q[63] ? (64'd0 - acc_q) : acc_q;
					neg_q   <= acc_q[63] ^ tneg_q;
					ph_q    <= 3'd0;
					state_q <= S_HMUL;
				end
				S_HMUL: begin
					if (ph_q == 3'd5) begin
						mres_q  <= mul_res;
						sat_q   <= sat_q | mul_sat;
						state_q <= S_HADD;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_HADD: begin
					acc_q <= add_res;
					sat_q <= sat_q | add_sat;
					if (term_q == 3'd0) begin
						res_q       <= add_res;
						status_q    <= (sat_q | add_sat) ? STATUS_SAT : STATUS_OK;
						res_valid_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						term_q  <= term_q - 3'd1;
						state_q <= S_HPREP;
					end
				end
				S_DONE: begin
					if (!result_stall) begin
						res_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign series_value = res_q;
	assign status       = status_q;

endmodule

/* hdl/ilps_checker.sv */
`include "inverse_log_power_series_eval_unit_macros.svh"

module ilps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_valid,
	input logic        sample_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [63:0] series_value,
	input logic [1:0]  status
);
	import ilps_pkg::*;

	`ILPS_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "no stall after accept")
	`ILPS_ASSERT_IMPL(a_no_accept_pending, result_valid, sample_stall, "sample open while result pending")
	`ILPS_ASSERT_IMPL(a_status_code, result_valid, status != 2'd3, "undefined status code")
	`ILPS_ASSERT_IMPL(a_invalid_zero, result_valid && (status == STATUS_INVALID), series_value == 64'd0, "invalid result not zero")
	`ILPS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(series_value), "stalled result changed")

endmodule

bind inverse_log_power_series_eval_unit ilps_checker u_ilps_checker (.*);
